// File: hw/rtl/grouped_team_queue_macros.svh
// Assertion macros for the grouped team queue
`ifndef GROUPED_TEAM_QUEUE_MACROS_SVH
`define GROUPED_TEAM_QUEUE_MACROS_SVH
// Implication checked every clock edge outside reset
`define GTQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Invariant checked every clock edge outside reset
`define GTQ_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/gtq_pkg.sv
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared types and constants of the grouped team queue.
// ----------------------------------------------------------------------------
`default_nettype none
package gtq_pkg;
	localparam int GROUPS_DEF      = 10;
	localparam int MEMBERS_DEF     = 64;
	localparam int GROUP_DEPTH_DEF = 32;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int CMD_BITS    = 2;
	localparam int DATA_BITS   = 32;
	localparam int GROUP_BITS  = 4;
	localparam int STATUS_BITS = 3;

	typedef enum logic [1:0] {
		CMD_DEFINE  = 2'd0,
		CMD_ENQUEUE = 2'd1,
		CMD_DEQUEUE = 2'd2,
		CMD_DEQ_ALT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DEQUEUED   = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_ENQUEUED   = 3'd2,
		ST_UNKNOWN    = 3'd3,
		ST_FULL       = 3'd4,
		ST_DEFINED    = 3'd5,
		ST_TABLE_FULL = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_EXEC,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the input transaction
		logic search;   // start the member search
		logic exec;     // perform the command
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic search_done;
	} sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/gtq_ctrl.sv
// ----------------------------------------------------------------------------
// gtq_ctrl
// Command sequencer: accept, search the member table, execute, present result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grouped_team_queue_macros.svh"
module gtq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output gtq_pkg::ctl_t      ctl,
	input  wire gtq_pkg::sts_t sts
);
	gtq_pkg::state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gtq_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			gtq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load   = 1'b1;
					ctl.search = 1'b1;
					state_d    = gtq_pkg::S_LOOKUP;
				end
			end
			gtq_pkg::S_LOOKUP: begin
				if (sts.search_done) state_d = gtq_pkg::S_EXEC;
			end
			gtq_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = gtq_pkg::S_OUT;
			end
			gtq_pkg::S_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						ctl.load   = 1'b1;
						ctl.search = 1'b1;
						state_d    = gtq_pkg::S_LOOKUP;
					end else begin
						state_d = gtq_pkg::S_IDLE;
					end
				end
			end
			default: state_d = gtq_pkg::S_IDLE;
		endcase
	end

	`GTQ_ASSERT_IMPL(a_exec_to_out, ctl.exec, state_d == gtq_pkg::S_OUT)
	`GTQ_ASSERT_ALWAYS(a_no_accept_busy, !(in_ready && (state_q == gtq_pkg::S_LOOKUP)))
	`GTQ_ASSERT_IMPL(a_load_search, ctl.load, ctl.search)
endmodule
`default_nettype wire

// File: hw/rtl/gtq_dpath.sv
// ----------------------------------------------------------------------------
// gtq_dpath
// Member table, group FIFOs in one element memory, and the group order ring.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grouped_team_queue_macros.svh"
module gtq_dpath #(
	parameter int GROUPS      = gtq_pkg::GROUPS_DEF,
	parameter int MEMBERS     = gtq_pkg::MEMBERS_DEF,
	parameter int GROUP_DEPTH = gtq_pkg::GROUP_DEPTH_DEF,
	parameter int VALUE_BITS  = gtq_pkg::VALUE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire gtq_pkg::ctl_t                      ctl,
	output gtq_pkg::sts_t                           sts,
	input  wire logic [gtq_pkg::CMD_BITS-1:0]       cmd,
	input  wire logic [gtq_pkg::DATA_BITS-1:0]      value,
	input  wire logic [gtq_pkg::GROUP_BITS-1:0]     group,
	output logic [gtq_pkg::STATUS_BITS-1:0]         status,
	output logic [gtq_pkg::DATA_BITS-1:0]           out_value
);
	localparam int MW  = $clog2(MEMBERS);
	localparam int CW  = $clog2(MEMBERS + 1);
	localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int OW  = $clog2(GROUPS + 1);
	localparam int DW  = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
	localparam int FW  = $clog2(GROUP_DEPTH + 1);
	localparam int EW  = $clog2(GROUPS * GROUP_DEPTH);
	localparam int VB  = (VALUE_BITS < gtq_pkg::DATA_BITS) ? VALUE_BITS : gtq_pkg::DATA_BITS;

	// captured transaction
	logic [gtq_pkg::CMD_BITS-1:0]   cmd_q;
	logic [VB-1:0]                  val_q;
	logic [gtq_pkg::GROUP_BITS-1:0] grp_q;

	// member table memory and search state
	logic [VB-1:0]                  mem_val [MEMBERS];
	logic [gtq_pkg::GROUP_BITS-1:0] mem_grp [MEMBERS];
	logic [CW-1:0]                  member_count_q;
	logic [CW-1:0]                  scan_q;
	logic                           scanning_q;
	logic                           rd_valid_q;
	logic [VB-1:0]                  rd_val_q;
	logic [gtq_pkg::GROUP_BITS-1:0] rd_grp_q;
	logic                           found_q;
	logic [gtq_pkg::GROUP_BITS-1:0] found_grp_q;

	// group bookkeeping
	logic [DW-1:0] group_head_q [GROUPS];
	logic [FW-1:0] group_fill_q [GROUPS];
	logic [GW-1:0] order_ring_q [GROUPS];
	logic [GW-1:0] order_head_q;
	logic [OW-1:0] order_fill_q;
	logic [VB-1:0] elem_mem [GROUPS * GROUP_DEPTH];

	logic is_define;
	assign is_define = (cmd_q == gtq_pkg::CMD_DEFINE);

	// capture input
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			val_q <= value[VB-1:0];
			grp_q <= group;
		end
	end

	// member scan: one table entry read per cycle, registered read data;
	// only an enqueue needs the search
	logic scan_end;
	assign scan_end = scanning_q && (found_q || (scan_q >= member_count_q) ||
		(cmd_q != gtq_pkg::CMD_ENQUEUE));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q  <= 1'b0;
			rd_valid_q  <= 1'b0;
			scan_q      <= '0;
			found_q     <= 1'b0;
			found_grp_q <= '0;
		end else if (ctl.search) begin
			scanning_q <= 1'b1;
			rd_valid_q <= 1'b0;
			scan_q     <= '0;
			found_q    <= 1'b0;
		end else if (scanning_q) begin
			if (rd_valid_q && !found_q && rd_val_q == val_q) begin
				found_q     <= 1'b1;
				found_grp_q <= rd_grp_q;
			end
			if (scan_end && !(rd_valid_q && !found_q && rd_val_q == val_q)) begin
				scanning_q <= 1'b0;
				rd_valid_q <= 1'b0;
			end else if (scan_q < member_count_q) begin
				rd_valid_q <= 1'b1;
				scan_q     <= scan_q + 1'b1;
			end else begin
				rd_valid_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		rd_val_q <= mem_val[scan_q[MW-1:0]];
		rd_grp_q <= mem_grp[scan_q[MW-1:0]];
	end
	assign sts.search_done = scan_end &&
		!(rd_valid_q && !found_q && rd_val_q == val_q);

	// command decisions
	logic [GW-1:0] eg;
	logic [GW-1:0] fg;
	logic [FW-1:0] efill;
	logic [FW-1:0] ffill;
	logic          grp_ok;
	logic          def_ok;
	logic          enq_ok;
	logic          deq_ok;
	logic [GW:0]   tail_sum;
	logic [GW-1:0] tail_idx;
	logic [DW:0]   slot_sum;
	logic [DW-1:0] slot;
	logic [EW-1:0] wr_addr;
	logic [EW-1:0] rd_addr;
	assign eg       = found_grp_q[GW-1:0];
	assign fg       = order_ring_q[order_head_q];
	assign efill    = group_fill_q[eg];
	assign ffill    = group_fill_q[fg];
	assign grp_ok   = ({{(32-gtq_pkg::GROUP_BITS){1'b0}}, grp_q} < GROUPS);
	assign def_ok   = (member_count_q < CW'(MEMBERS)) && grp_ok;
	assign enq_ok   = found_q && (efill < FW'(GROUP_DEPTH)) &&
		((efill != '0) || (order_fill_q < OW'(GROUPS)));
	assign deq_ok   = (order_fill_q != '0);
	assign tail_sum = {1'b0, order_head_q} + (GW+1)'(order_fill_q);
	assign tail_idx = (tail_sum >= (GW+1)'(GROUPS)) ?
		GW'(tail_sum - (GW+1)'(GROUPS)) : tail_sum[GW-1:0];
	assign slot_sum = (efill == '0) ? '0 : ({1'b0, group_head_q[eg]} + (DW+1)'(efill));
	assign slot     = (slot_sum >= (DW+1)'(GROUP_DEPTH)) ?
		DW'(slot_sum - (DW+1)'(GROUP_DEPTH)) : slot_sum[DW-1:0];
	assign wr_addr  = EW'(eg * GROUP_DEPTH) + EW'(slot);
	assign rd_addr  = EW'(fg * GROUP_DEPTH) + EW'(group_head_q[fg]);

	// member table write
	always_ff @(posedge clk) begin
		if (ctl.exec && is_define && def_ok) begin
			mem_val[member_count_q[MW-1:0]] <= val_q;
			mem_grp[member_count_q[MW-1:0]] <= grp_q;
		end
	end

	// element memory, write and registered read held with the result
	logic [VB-1:0] elem_rd;
	always_ff @(posedge clk) begin
		if (ctl.exec && cmd_q == gtq_pkg::CMD_ENQUEUE && enq_ok) elem_mem[wr_addr] <= val_q;
		if (ctl.exec) elem_rd <= elem_mem[rd_addr];
	end

	// bookkeeping update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_count_q <= '0;
			order_head_q   <= '0;
			order_fill_q   <= '0;
			for (int i = 0; i < GROUPS; i++) begin
				group_head_q[i] <= '0;
				group_fill_q[i] <= '0;
				order_ring_q[i] <= '0;
			end
		end else if (ctl.exec) begin
			case (cmd_q)
				gtq_pkg::CMD_DEFINE: begin
					if (def_ok) member_count_q <= member_count_q + 1'b1;
				end
				gtq_pkg::CMD_ENQUEUE: begin
					if (enq_ok) begin
						if (efill == '0) begin
							order_ring_q[tail_idx] <= eg;
							order_fill_q           <= order_fill_q + 1'b1;
							group_head_q[eg]       <= '0;
						end
						group_fill_q[eg] <= efill + 1'b1;
					end
				end
				default: begin
					if (deq_ok) begin
						group_head_q[fg] <= (group_head_q[fg] == DW'(GROUP_DEPTH - 1)) ?
							'0 : group_head_q[fg] + 1'b1;
						group_fill_q[fg] <= ffill - 1'b1;
						if (ffill == FW'(1)) begin
							order_head_q <= (order_head_q == GW'(GROUPS - 1)) ?
								'0 : order_head_q + 1'b1;
							order_fill_q <= order_fill_q - 1'b1;
						end
					end
				end
			endcase
		end
	end

	// result register
	logic deq_hit_q;
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			deq_hit_q <= deq_ok &&
				(cmd_q inside {gtq_pkg::CMD_DEQUEUE, gtq_pkg::CMD_DEQ_ALT});
			case (cmd_q)
				gtq_pkg::CMD_DEFINE:
					status <= (member_count_q >= CW'(MEMBERS)) ? gtq_pkg::ST_TABLE_FULL :
						(!grp_ok ? gtq_pkg::ST_UNKNOWN : gtq_pkg::ST_DEFINED);
				gtq_pkg::CMD_ENQUEUE:
					status <= !found_q ? gtq_pkg::ST_UNKNOWN :
						(enq_ok ? gtq_pkg::ST_ENQUEUED : gtq_pkg::ST_FULL);
				default: begin
					status <= deq_ok ? gtq_pkg::ST_DEQUEUED : gtq_pkg::ST_EMPTY;
				end
			endcase
		end
	end
	assign out_value = deq_hit_q ? gtq_pkg::DATA_BITS'(elem_rd) : '0;

	`GTQ_ASSERT_ALWAYS(a_order_bound, order_fill_q <= OW'(GROUPS))
	`GTQ_ASSERT_ALWAYS(a_count_bound, member_count_q <= CW'(MEMBERS))
	`GTQ_ASSERT_IMPL(a_exec_idle_scan, ctl.exec, !scanning_q)
endmodule
`default_nettype wire

// File: hw/rtl/grouped_team_queue.sv
// ----------------------------------------------------------------------------
// grouped_team_queue
// Team queue: member table, per-group FIFOs and group order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: define member, enqueue or
//   dequeue (tdata = cmd, value, group from bit 0 up). m_axis returns one
//   result per command (tdata = status, out_value from bit 0 up).
//   Sequence: an enqueue searches the member table one entry per cycle, then
//   executes and presents its result; define and dequeue skip the search and
//   execute at once after the lookup state. One command is in flight at a
//   time; the next is accepted in the cycle its predecessor's result is taken.
//   Reset clears the member count, group fills and group order at once; no
//   clearing pass is needed. Memory contents are undefined until written.
//   When the receiver stalls, the result is held and no new command is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module grouped_team_queue #(
	parameter int GROUPS      = gtq_pkg::GROUPS_DEF,
	parameter int MEMBERS     = gtq_pkg::MEMBERS_DEF,
	parameter int GROUP_DEPTH = gtq_pkg::GROUP_DEPTH_DEF,
	parameter int VALUE_BITS  = gtq_pkg::VALUE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // cmd[1:0], value[33:2], group[37:34]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata    // status[2:0], out_value[34:3]
);
	gtq_pkg::ctl_t ctl;
	gtq_pkg::sts_t sts;
	logic [gtq_pkg::STATUS_BITS-1:0] status;
	logic [gtq_pkg::DATA_BITS-1:0]   out_value;

	gtq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.ctl(ctl), .sts(sts)
	);

	gtq_dpath #(
		.GROUPS(GROUPS), .MEMBERS(MEMBERS),
		.GROUP_DEPTH(GROUP_DEPTH), .VALUE_BITS(VALUE_BITS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(s_axis_tdata[1:0]), .value(s_axis_tdata[33:2]),
		.group(s_axis_tdata[37:34]),
		.status(status), .out_value(out_value)
	);

	assign m_axis_tdata = {5'd0, out_value, status};
endmodule
`default_nettype wire
